FILE: rtl/bin_image_record_loader_defines.svh
// Assertion macros shared by the checker of the image record loader.
// Depends on nothing; included by the checker file by its bare name.
`ifndef BIN_IMAGE_RECORD_LOADER_DEFINES_SVH
`define BIN_IMAGE_RECORD_LOADER_DEFINES_SVH

// Checks a property on every rising edge while reset is released.
`define BIRL_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks a property on every rising edge, reset included.
`define BIRL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/birl_pkg.sv
// Package of the image record loader: phase codes, result kinds, the result
// record type and the signature table. Depends on nothing.
`timescale 1ns / 1ps

package birl_pkg;

  typedef enum logic [7:0] {
    PH_SIG    = 8'b0000_0001,
    PH_HSTART = 8'b0000_0010,
    PH_HLEN   = 8'b0000_0100,
    PH_RSTART = 8'b0000_1000,
    PH_RLEN   = 8'b0001_0000,
    PH_RSUM   = 8'b0010_0000,
    PH_DATA   = 8'b0100_0000,
    PH_HALT   = 8'b1000_0000
  } phase_t;

  localparam logic [1:0] KIND_WRITE  = 2'd0;
  localparam logic [1:0] KIND_DONE   = 2'd1;
  localparam logic [1:0] KIND_BADSIG = 2'd2;
  localparam logic [1:0] KIND_CSFAIL = 2'd3;

  localparam logic [2:0]  SIG_LAST        = 3'd6;
  localparam logic [7:0]  VTOP_RESET      = 8'h80;
  localparam logic [31:0] PHYS_BASE_RESET = 32'h3000_0000;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] addr;
    logic [7:0]  data;
    logic [31:0] start;
    logic [31:0] len;
    logic        last;
  } result_t;

  function automatic logic [7:0] sig_byte(input logic [2:0] pos);
    logic [7:0] val;
    case (pos)
      3'd0: val = 8'h42;
      3'd1: val = 8'h30;
      3'd2: val = 8'h30;
      3'd3: val = 8'h30;
      3'd4: val = 8'h46;
      3'd5: val = 8'h46;
      3'd6: val = 8'h0A;
      default: val = 8'h00;
    endcase
    return val;
  endfunction

endpackage

FILE: rtl/bin_image_record_loader.sv
// The results of each input transfer are registered into the result queue, which drives the output.
// Throughput: one byte per cycle; the four-entry result queue takes both results of a
// byte that causes two (last data byte with a checksum failure), so the input is held
// only while three or more results wait behind a stalled output.
// Synchronous active-low reset clears the parser, the queue and sets the physical base
// to 0x30000000. Depends on birl_pkg.
`timescale 1ns / 1ps

module bin_image_record_loader (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [7:0]    in_tdata,   // [7:0] byte_value
  input  logic          in_tuser,   // [0] begin_req
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [103:0]  out_tdata,  // [31:0] address, [39:32] write_data,
                                    // [71:40] image_start_phys, [103:72] image_length
  output logic [1:0]    out_tuser,  // [1:0] result_kind
  output logic          out_tlast,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [31:0]   cfg_data
);
  import birl_pkg::*;

  phase_t      phase_r, phase_nxt, cur_phase;
  logic [2:0]  pos_r, pos_nxt, cur_pos;
  logic [31:0] word_r, word_nxt, cur_word;
  logic [31:0] hstart_r, hstart_nxt, cur_hstart;
  logic [31:0] hlen_r, hlen_nxt, cur_hlen;
  logic [7:0]  vtop_r, vtop_nxt, cur_vtop;
  logic [31:0] raddr_r, raddr_nxt, cur_raddr;
  logic [31:0] brem_r, brem_nxt, cur_brem;
  logic [31:0] esum_r, esum_nxt, cur_esum;
  logic [31:0] rsum_r, rsum_nxt, cur_rsum;
  logic [31:0] base_r;

  result_t          q_mem [QDEPTH];
  logic [QAW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QAW:0]     count_r;

  logic             in_fire, out_fire;
  logic [1:0]       n_res;
  result_t          res0, res1;
  logic [7:0]       b;
  logic             beg;
  logic [31:0]      word_full, word_part;
  logic             pos_done;
  logic [2:0]       pos_inc;
  logic [31:0]      brem_dec, rsum_add;

  function automatic logic [31:0] to_phys(input logic [31:0] a, input logic [7:0] vt,
                                           input logic [31:0] pb);
    return a - {vt, 24'h000000} + pb;
  endfunction

  assign b         = in_tdata;
  assign beg       = in_tuser;
  assign in_fire   = in_tvalid && in_tready;
  assign out_fire  = out_tvalid && out_tready;
  assign in_tready = (count_r <= (QAW+1)'(QDEPTH - 2));
  assign cfg_ready = 1'b1;

  always_comb begin
    cur_phase  = beg ? PH_SIG : phase_r;
    cur_pos    = beg ? 3'd0 : pos_r;
    cur_word   = beg ? 32'd0 : word_r;
    cur_hstart = beg ? 32'd0 : hstart_r;
    cur_hlen   = beg ? 32'd0 : hlen_r;
    cur_vtop   = beg ? VTOP_RESET : vtop_r;
    cur_raddr  = beg ? 32'd0 : raddr_r;
    cur_brem   = beg ? 32'd0 : brem_r;
    cur_esum   = beg ? 32'd0 : esum_r;
    cur_rsum   = beg ? 32'd0 : rsum_r;

    word_full = {b, cur_word[23:0]};
    word_part = ((cur_pos[1:0] == 2'd0) ? 32'd0 : cur_word)
                | (32'(b) << {cur_pos[1:0], 3'b000});
    pos_done  = (cur_pos[1:0] == 2'd3);
    pos_inc   = {1'b0, cur_pos[1:0] + 2'd1};
    brem_dec  = cur_brem - 32'd1;
    rsum_add  = cur_rsum + 32'(b);

    phase_nxt  = cur_phase;
    pos_nxt    = cur_pos;
    word_nxt   = cur_word;
    hstart_nxt = cur_hstart;
    hlen_nxt   = cur_hlen;
    vtop_nxt   = cur_vtop;
    raddr_nxt  = cur_raddr;
    brem_nxt   = cur_brem;
    esum_nxt   = cur_esum;
    rsum_nxt   = cur_rsum;
    n_res      = 2'd0;
    res0       = '0;
    res1       = '0;

    case (cur_phase)
      PH_SIG: begin
        if (cur_pos > SIG_LAST || b != sig_byte(cur_pos)) begin
          res0.kind = KIND_BADSIG;
          res0.last = 1'b1;
          n_res     = 2'd1;
          phase_nxt = PH_HALT;
        end else if (cur_pos == SIG_LAST) begin
          pos_nxt   = 3'd0;
          phase_nxt = PH_HSTART;
        end else begin
          pos_nxt = cur_pos + 3'd1;
        end
      end
      PH_HSTART, PH_HLEN, PH_RSTART, PH_RLEN: begin
        word_nxt = word_part;
        pos_nxt  = pos_done ? 3'd0 : pos_inc;
        if (pos_done) begin
          case (cur_phase)
            PH_HSTART: begin
              hstart_nxt = word_full;
              vtop_nxt   = b;
              phase_nxt  = PH_HLEN;
            end
            PH_HLEN: begin
              hlen_nxt  = word_full;
              phase_nxt = PH_RSTART;
            end
            PH_RSTART: begin
              raddr_nxt = word_full;
              phase_nxt = PH_RLEN;
            end
            default: begin
              brem_nxt  = word_full;
              phase_nxt = PH_RSUM;
            end
          endcase
        end
      end
      PH_RSUM: begin
        word_nxt = word_part;
        pos_nxt  = pos_done ? 3'd0 : pos_inc;
        if (pos_done) begin
          esum_nxt = word_full;
          rsum_nxt = 32'd0;
          if (cur_raddr == 32'd0 && word_full == 32'd0) begin
            res0.kind  = KIND_DONE;
            res0.addr  = to_phys(cur_brem, cur_vtop, base_r);
            res0.start = to_phys(cur_hstart, cur_vtop, base_r);
            res0.len   = cur_hlen;
            res0.last  = 1'b1;
            n_res      = 2'd1;
            phase_nxt  = PH_HALT;
          end else if (cur_brem == 32'd0) begin
            if (word_full != 32'd0) begin
              res0.kind = KIND_CSFAIL;
              res0.last = 1'b1;
              n_res     = 2'd1;
              phase_nxt = PH_HALT;
            end else begin
              phase_nxt = PH_RSTART;
            end
          end else begin
            phase_nxt = PH_DATA;
          end
        end
      end
      PH_DATA: begin
        res0.kind = KIND_WRITE;
        res0.addr = to_phys(cur_raddr, cur_vtop, base_r);
        res0.data = b;
        n_res     = 2'd1;
        rsum_nxt  = rsum_add;
        raddr_nxt = cur_raddr + 32'd1;
        brem_nxt  = brem_dec;
        if (brem_dec == 32'd0) begin
          if (rsum_add != cur_esum) begin
            res1.kind = KIND_CSFAIL;
            res1.last = 1'b1;
            n_res     = 2'd2;
            phase_nxt = PH_HALT;
          end else begin
            res0.last = 1'b1;
            phase_nxt = PH_RSTART;
          end
        end else begin
          res0.last = 1'b1;
        end
      end
      PH_HALT: begin
        phase_nxt = PH_HALT;
      end
      default: begin
        phase_nxt = PH_HALT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_SIG;
      pos_r    <= 3'd0;
      word_r   <= 32'd0;
      hstart_r <= 32'd0;
      hlen_r   <= 32'd0;
      vtop_r   <= VTOP_RESET;
      raddr_r  <= 32'd0;
      brem_r   <= 32'd0;
      esum_r   <= 32'd0;
      rsum_r   <= 32'd0;
    end else if (in_fire) begin
      phase_r  <= phase_nxt;
      pos_r    <= pos_nxt;
      word_r   <= word_nxt;
      hstart_r <= hstart_nxt;
      hlen_r   <= hlen_nxt;
      vtop_r   <= vtop_nxt;
      raddr_r  <= raddr_nxt;
      brem_r   <= brem_nxt;
      esum_r   <= esum_nxt;
      rsum_r   <= rsum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= PHYS_BASE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      base_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && n_res != 2'd0) begin
      q_mem[wr_ptr_r] <= res0;
    end
    if (in_fire && n_res == 2'd2) begin
      q_mem[wr_ptr_r + QAW'(1)] <= res1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (in_fire) begin
        wr_ptr_r <= wr_ptr_r + QAW'(n_res);
      end
      if (out_fire) begin
        rd_ptr_r <= rd_ptr_r + QAW'(1);
      end
      count_r <= count_r + (QAW+1)'(in_fire ? n_res : 2'd0) - (QAW+1)'(out_fire);
    end
  end

  assign out_tvalid = (count_r != '0);
  assign out_tuser  = q_mem[rd_ptr_r].kind;
  assign out_tlast  = q_mem[rd_ptr_r].last;
  assign out_tdata  = {q_mem[rd_ptr_r].len, q_mem[rd_ptr_r].start,
                       q_mem[rd_ptr_r].data, q_mem[rd_ptr_r].addr};

endmodule

FILE: rtl/birl_checker.sv
// Port-level checker for the image record loader and its bind statement.
// Depends on birl_pkg and bin_image_record_loader_defines.svh.
`timescale 1ns / 1ps
`include "bin_image_record_loader_defines.svh"

module birl_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          out_tvalid,
  input logic          out_tready,
  input logic [103:0]  out_tdata,
  input logic [1:0]    out_tuser,
  input logic          out_tlast
);
  import birl_pkg::*;

  `BIRL_ASSERT(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast), "Stalled output transfer changed")
  `BIRL_ASSERT(a_end_is_last, clk, rst_n, out_tvalid && out_tuser != KIND_WRITE |-> out_tlast, "Done or error result is not the last of its byte")
  `BIRL_ASSERT(a_only_write_first, clk, rst_n, out_tvalid && !out_tlast |-> out_tuser == KIND_WRITE, "Only a write may precede another result of the same byte")
  `BIRL_ASSERT(a_no_data_on_status, clk, rst_n, out_tvalid && out_tuser != KIND_WRITE |-> out_tdata[39:32] == 8'd0, "Status result carries write data")

endmodule

bind bin_image_record_loader birl_checker u_birl_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

FILE: dv/bin_image_record_loader_test.sv
// Self-checking testbench for the image record loader: byte streams of images, broken images
// and noise go in, and every result transfer is compared with a predicted parse of the same bytes.
// Depends on birl_pkg and bin_image_record_loader.
`timescale 1ns / 1ps

module bin_image_record_loader_test;
  import birl_pkg::*;

  typedef struct packed {
    logic       begin_req;
    logic [7:0] val;
  } image_byte_t;

  // Byte i of the signature sits in bits [8*i+7:8*i].
  localparam logic [55:0] SIGNATURE = 56'h0A_46_46_30_30_30_42;

  logic         clk;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [7:0]   in_tdata = 8'h00;
  logic         in_tuser = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [103:0] out_tdata;
  logic [1:0]   out_tuser;
  logic         out_tlast;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [31:0]  cfg_data = 32'h0;

  image_byte_t pending_bytes[$];
  result_t     expected_results[$];
  int          pushed_bytes = 0;
  int          accepted_bytes = 0;
  int          fail_count = 0;
  int          tx_idle = 38;
  int          rx_idle = 51;
  int          stall_left = 0;
  logic        stall_done = 1'b0;

  logic [31:0] base_m;
  phase_t      p_phase;
  logic [2:0]  p_pos;
  logic [31:0] p_word;
  logic [31:0] p_hstart;
  logic [31:0] p_hlen;
  logic [7:0]  p_vtop;
  logic [31:0] p_raddr;
  logic [31:0] p_remain;
  logic [31:0] p_esum;
  logic [31:0] p_rsum;

  bin_image_record_loader i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  function void restart_parse();
    p_phase  = PH_SIG;
    p_pos    = 3'd0;
    p_word   = 32'h0;
    p_hstart = 32'h0;
    p_hlen   = 32'h0;
    p_vtop   = VTOP_RESET;
    p_raddr  = 32'h0;
    p_remain = 32'h0;
    p_esum   = 32'h0;
    p_rsum   = 32'h0;
  endfunction

  function logic [31:0] phys_addr(input logic [31:0] a);
    return a - {p_vtop, 24'h0} + base_m;
  endfunction

  function void add_result(input logic [1:0] kind, input logic [31:0] addr,
                           input logic [7:0] data, input logic [31:0] start,
                           input logic [31:0] len);
    result_t r;
    r.kind  = kind;
    r.addr  = addr;
    r.data  = data;
    r.start = start;
    r.len   = len;
    r.last  = 1'b0;
    expected_results.push_back(r);
  endfunction

  function logic take_word_byte(input logic [7:0] b);
    if (p_pos[1:0] == 2'd0) p_word = 32'h0;
    p_word = p_word | ({24'h0, b} << (8 * p_pos[1:0]));
    if (p_pos[1:0] == 2'd3) begin
      p_pos = 3'd0;
      return 1'b1;
    end
    p_pos = {1'b0, p_pos[1:0]} + 3'd1;
    return 1'b0;
  endfunction

  function void parse_byte(input logic begin_req, input logic [7:0] b);
    int queued;
    queued = expected_results.size();
    if (begin_req) restart_parse();
    case (p_phase)
      PH_SIG: begin
        if (p_pos > SIG_LAST || b != SIGNATURE[8 * p_pos +: 8]) begin
          add_result(KIND_BADSIG, 32'h0, 8'h0, 32'h0, 32'h0);
          p_phase = PH_HALT;
        end else if (p_pos == SIG_LAST) begin
          p_pos   = 3'd0;
          p_phase = PH_HSTART;
        end else begin
          p_pos = p_pos + 3'd1;
        end
      end
      PH_HSTART: begin
        if (take_word_byte(b)) begin
          p_hstart = p_word;
          p_vtop   = p_word[31:24];
          p_phase  = PH_HLEN;
        end
      end
      PH_HLEN: begin
        if (take_word_byte(b)) begin
          p_hlen  = p_word;
          p_phase = PH_RSTART;
        end
      end
      PH_RSTART: begin
        if (take_word_byte(b)) begin
          p_raddr = p_word;
          p_phase = PH_RLEN;
        end
      end
      PH_RLEN: begin
        if (take_word_byte(b)) begin
          p_remain = p_word;
          p_phase  = PH_RSUM;
        end
      end
      PH_RSUM: begin
        if (take_word_byte(b)) begin
          p_esum = p_word;
          p_rsum = 32'h0;
          if (p_raddr == 32'h0 && p_esum == 32'h0) begin
            add_result(KIND_DONE, phys_addr(p_remain), 8'h0, phys_addr(p_hstart), p_hlen);
            p_phase = PH_HALT;
          end else if (p_remain == 32'h0) begin
            if (p_esum != 32'h0) begin
              add_result(KIND_CSFAIL, 32'h0, 8'h0, 32'h0, 32'h0);
              p_phase = PH_HALT;
            end else begin
              p_phase = PH_RSTART;
            end
          end else begin
            p_phase = PH_DATA;
          end
        end
      end
      PH_DATA: begin
        add_result(KIND_WRITE, phys_addr(p_raddr), b, 32'h0, 32'h0);
        p_rsum   = p_rsum + {24'h0, b};
        p_raddr  = p_raddr + 32'd1;
        p_remain = p_remain - 32'd1;
        if (p_remain == 32'h0) begin
          if (p_rsum != p_esum) begin
            add_result(KIND_CSFAIL, 32'h0, 8'h0, 32'h0, 32'h0);
            p_phase = PH_HALT;
          end else begin
            p_phase = PH_RSTART;
          end
        end
      end
      default: p_phase = PH_HALT;
    endcase
    if (expected_results.size() > queued)
      expected_results[expected_results.size() - 1].last = 1'b1;
  endfunction

  function void check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin : drive
    image_byte_t nxt;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        parse_byte(in_tuser, in_tdata);
        accepted_bytes++;
      end
      if (cfg_valid && cfg_ready) base_m = cfg_data;
      if (!in_tvalid || in_tready) begin
        if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= tx_idle) begin
          nxt = pending_bytes.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= nxt.val;
          in_tuser  <= nxt.begin_req;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // One long hold-off lets the result queue fill and back up the input.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (!stall_done && accepted_bytes >= 400) begin
      stall_done <= 1'b1;
      stall_left <= 300;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= rx_idle);
    end
  end

  always @(posedge clk) begin : monitor
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result transfer: kind %0d address 0x%0h", out_tuser, out_tdata[31:0]);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        check_field("result_kind", {30'h0, want.kind}, {30'h0, out_tuser});
        check_field("address", want.addr, out_tdata[31:0]);
        check_field("write_data", {24'h0, want.data}, {24'h0, out_tdata[39:32]});
        check_field("image_start_phys", want.start, out_tdata[71:40]);
        check_field("image_length", want.len, out_tdata[103:72]);
        check_field("last_of_run", {31'h0, want.last}, {31'h0, out_tlast});
      end
    end
  end

  task automatic push_byte(input logic begin_req, input logic [7:0] val);
    image_byte_t e;
    e.begin_req = begin_req;
    e.val       = val;
    pending_bytes.push_back(e);
    pushed_bytes++;
  endtask

  task automatic push_word(input logic [31:0] w);
    int i;
    for (i = 0; i < 4; i++) push_byte(1'b0, w[8 * i +: 8]);
  endtask

  task automatic push_sig(input int count, input logic with_begin);
    int i;
    for (i = 0; i < count; i++) push_byte(with_begin && i == 0, SIGNATURE[8 * i +: 8]);
  endtask

  task automatic push_record(input logic [31:0] start, input int len, input logic [31:0] flip);
    logic [7:0]  d[$];
    logic [7:0]  v;
    logic [31:0] sum;
    int          i;
    sum = 32'h0;
    for (i = 0; i < len; i++) begin
      v = 8'($urandom);
      d.push_back(v);
      sum = sum + {24'h0, v};
    end
    push_word(start);
    push_word(32'(len));
    push_word(sum ^ flip);
    for (i = 0; i < len; i++) push_byte(1'b0, d[i]);
  endtask

  task automatic push_end(input logic [31:0] launch);
    push_word(32'h0);
    push_word(launch);
    push_word(32'h0);
  endtask

  task automatic push_scenario();
    int          pick;
    int          nrec;
    int          bad;
    int          i;
    int          len;
    int          k;
    logic [31:0] hstart;
    logic [31:0] start;
    logic [31:0] flip;
    logic [7:0]  v;
    pick = $urandom_range(0, 99);
    if (pick < 65) begin
      hstart = $urandom;
      nrec   = $urandom_range(0, 3);
      bad    = ($urandom_range(0, 99) < 20) ? $urandom_range(0, 3) : -1;
      push_sig(7, 1'b1);
      push_word(hstart);
      push_word($urandom);
      for (i = 0; i < nrec; i++) begin
        len   = ($urandom_range(0, 99) < 20) ? 0 : $urandom_range(1, 6);
        start = $urandom;
        if ($urandom_range(0, 1) == 0) start[31:24] = hstart[31:24];
        if (start == 32'h0) start = 32'h1;
        flip = (i == bad) ? (32'h1 << $urandom_range(0, 31)) : 32'h0;
        push_record(start, len, flip);
        if (flip != 32'h0) return;
      end
      push_end($urandom);
      k = $urandom_range(0, 2);
      repeat (k) push_byte(1'b0, 8'($urandom));
    end else if (pick < 75) begin
      k = $urandom_range(0, 6);
      push_sig(k, 1'b1);
      v = SIGNATURE[8 * k +: 8] ^ (8'h1 << $urandom_range(0, 7));
      push_byte(k == 0, v);
    end else if (pick < 85) begin
      push_sig(7, 1'b1);
      push_word($urandom);
      push_word($urandom);
      k = $urandom_range(0, 14);
      repeat (k) push_byte(1'b0, 8'($urandom));
    end else begin
      k = $urandom_range(1, 6);
      repeat (k) push_byte($urandom_range(0, 3) == 0, 8'($urandom));
    end
  endtask

  task automatic wait_drain();
    do @(negedge clk);
    while (pending_bytes.size() != 0 || in_tvalid || expected_results.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_base(input logic [31:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    int ph;
    int goal;
    restart_parse();
    base_m = PHYS_BASE_RESET;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // The first image is taken straight after reset without a begin request.
    push_sig(7, 1'b0);
    push_word(32'h8000_1000);
    push_word(32'h0);
    push_record(32'hFFFF_FFFE, 3, 32'h0);
    push_record(32'h8000_0010, 0, 32'h0);
    push_end(32'hFFFF_FFFF);
    push_byte(1'b0, 8'h42);
    push_byte(1'b1, 8'h43);
    push_sig(7, 1'b1);
    push_word(32'h0);
    push_word(32'hFFFF_FFFF);
    push_record(32'h0000_0040, 0, 32'h1);
    push_sig(4, 1'b1);
    push_sig(7, 1'b1);
    push_word(32'hFF00_0000);
    push_word(32'h0000_0200);
    push_record(32'hFF00_0100, 2, 32'h8000_0000);
    wait_drain();

    // This image is split by a base change part way through its records.
    push_sig(7, 1'b1);
    push_word(32'h0123_4567);
    push_word(32'h0000_0100);
    push_record(32'h0123_4600, 2, 32'h0);
    wait_drain();
    write_base(32'hFFFF_FFFF);
    push_record(32'h0123_4700, 2, 32'h0);
    push_end(32'h0);
    wait_drain();
    write_base(32'h0);

    for (ph = 0; ph < 6; ph++) begin
      if (ph < 2) begin
        tx_idle = 38;
        rx_idle = 51;
      end else if (ph < 4) begin
        tx_idle = 51;
        rx_idle = 38;
      end else begin
        tx_idle = 0;
        rx_idle = 0;
      end
      goal = pushed_bytes + 50;
      while (pushed_bytes < goal) push_scenario();
      wait_drain();
      case (ph)
        0: write_base($urandom);
        1: write_base(32'h8000_0000);
        2: write_base(32'hFFFF_FFFF);
        3: write_base($urandom);
        4: write_base(32'h3000_0000);
        default: ;
      endcase
    end

    repeat (20) @(posedge clk);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/birl_pkg.sv
rtl/bin_image_record_loader.sv
rtl/birl_checker.sv
dv/bin_image_record_loader_test.sv
